/* sv/text_console_writer_assert.svh */
// Assertion macros for the text console writer checker.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// Used by tcw_ctrl and text_console_writer; no dependencies.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // widest cell address for the supported geometry (256 x 128)
    localparam int ADDR_MAX_W   = 15;
    localparam int CELL_W       = 16;
    localparam int CURSOR_OUT_W = 11;

    localparam logic [7:0] BLANK_ATTR       = 8'h0F;
    localparam logic [7:0] SPACE_CHAR       = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR     = 8'd10;
    localparam logic [7:0] BACKSPACE_CHAR   = 8'd8;
    localparam logic [7:0] DEFAULT_ATTR_RST = 8'h0F;

    // register index taken from paddr[2]
    localparam logic REG_DEFAULT_ATTR = 1'b0;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCROLL,
        ST_FILL,
        ST_PUT,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] waddr;
        logic [CELL_W-1:0]     wdata;
        logic                  re;
        logic [ADDR_MAX_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

/* sv/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the screen cells.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/tcw_ctrl.sv */
// Sequencer and cursor datapath of the text console writer.
// Depends on tcw_pkg; drives the screen RAM through a ram_req_t bundle.
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [1:0]              action,
    input  wire logic [7:0]              char_code,
    input  wire logic [7:0]              attribute,
    input  wire logic                    use_default,
    input  wire logic                    at_cursor,
    input  wire logic [6:0]              column,
    input  wire logic [4:0]              row,
    input  wire logic [7:0]              default_attribute,
    input  wire logic [CELL_W-1:0]       ram_rdata,
    output ram_req_t                     ram_req,
    output logic                         busy,
    output logic                         done,
    output logic [CURSOR_OUT_W-1:0]      cursor_position,
    output logic [7:0]                   cell_char,
    output logic [7:0]                   cell_attribute
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int ROWW  = $clog2(ROWS + 1);

    localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, SPACE_CHAR};

    state_t state_reg, state_next;

    logic [CW-1:0]   cursor_reg, cursor_next;
    logic [COLW-1:0] ccol_reg, ccol_next;
    logic [ROWW-1:0] crow_reg, crow_next;
    logic            pend_reg, pend_next;
    logic            put_pend_reg, put_pend_next;

    logic [1:0]      act_reg;
    logic [7:0]      ch_reg;
    logic [7:0]      attr_reg;
    logic            at_cur_reg;
    logic [6:0]      col_reg;
    logic [4:0]      row_reg;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   dst_reg, dst_next;
    logic [7:0]      rd_char_reg, rd_char_next;
    logic [7:0]      rd_attr_reg, rd_attr_next;

    logic                  in_range;
    logic [ADDR_MAX_W-1:0] pos_full;
    logic [AW-1:0]         pos_addr;
    logic [CW-1:0]         cnt_inc;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [CELL_W-1:0]     wdata;
    logic                  re;
    logic [AW-1:0]         raddr;

    assign in_range = (9'(col_reg) < 9'(COLUMNS)) && (8'(row_reg) < 8'(ROWS));
    assign pos_full = ADDR_MAX_W'(row_reg) * ADDR_MAX_W'(COLUMNS) + ADDR_MAX_W'(col_reg);
    assign pos_addr = pos_full[AW-1:0];

    // sweep counter increment, shared by scroll copy and fill
    assign cnt_inc = cnt_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cursor_reg   <= '0;
            ccol_reg     <= '0;
            crow_reg     <= '0;
            pend_reg     <= 1'b0;
            put_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            ccol_reg     <= ccol_next;
            crow_reg     <= crow_next;
            pend_reg     <= pend_next;
            put_pend_reg <= put_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            act_reg    <= action;
            ch_reg     <= char_code;
            attr_reg   <= use_default ? default_attribute : attribute;
            at_cur_reg <= at_cursor;
            col_reg    <= column;
            row_reg    <= row;
        end
        cnt_reg     <= cnt_next;
        dst_reg     <= dst_next;
        rd_char_reg <= rd_char_next;
        rd_attr_reg <= rd_attr_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        ccol_next     = ccol_reg;
        crow_next     = crow_reg;
        pend_next     = pend_reg;
        put_pend_next = put_pend_reg;
        cnt_next      = cnt_reg;
        dst_next      = dst_reg;
        rd_char_next  = rd_char_reg;
        rd_attr_next  = rd_attr_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        re            = 1'b0;
        raddr         = '0;
        done          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                rd_char_next = '0;
                rd_attr_next = '0;
                state_next   = ST_DONE;
                case (act_reg)
                    ACT_PUT:
                    begin
                        if (ch_reg == NEWLINE_CHAR)
                        begin
                            if (crow_reg >= ROWW'(ROWS - 1))
                            begin
                                // scroll, then the cursor lands on the start of its own row
                                cursor_next   = cursor_reg - CW'(ccol_reg);
                                ccol_next     = '0;
                                cnt_next      = CW'(COLUMNS);
                                pend_next     = 1'b0;
                                put_pend_next = 1'b0;
                                state_next    = ST_SCROLL;
                            end
                            else
                            begin
                                cursor_next = cursor_reg - CW'(ccol_reg) + CW'(COLUMNS);
                                ccol_next   = '0;
                                crow_next   = crow_reg + ROWW'(1);
                            end
                        end
                        else if (ch_reg == BACKSPACE_CHAR)
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - CW'(1);
                                we          = 1'b1;
                                waddr       = AW'(cursor_reg - CW'(1));
                                wdata       = {attr_reg, SPACE_CHAR};
                                if (ccol_reg == '0)
                                begin
                                    ccol_next = COLW'(COLUMNS - 1);
                                    crow_next = crow_reg - ROWW'(1);
                                end
                                else
                                begin
                                    ccol_next = ccol_reg - COLW'(1);
                                end
                            end
                        end
                        else if (at_cur_reg)
                        begin
                            if (cursor_reg == CW'(CELLS))
                            begin
                                // screen full: scroll, then write the first cell of the last row
                                cursor_next   = CW'(CELLS - COLUMNS + 1);
                                ccol_next     = COLW'(1);
                                crow_next     = ROWW'(ROWS - 1);
                                cnt_next      = CW'(COLUMNS);
                                pend_next     = 1'b0;
                                put_pend_next = 1'b1;
                                state_next    = ST_SCROLL;
                            end
                            else
                            begin
                                we          = 1'b1;
                                waddr       = cursor_reg[AW-1:0];
                                wdata       = {attr_reg, ch_reg};
                                cursor_next = cursor_reg + CW'(1);
                                if (ccol_reg == COLW'(COLUMNS - 1))
                                begin
                                    ccol_next = '0;
                                    crow_next = crow_reg + ROWW'(1);
                                end
                                else
                                begin
                                    ccol_next = ccol_reg + COLW'(1);
                                end
                            end
                        end
                        else if (in_range)
                        begin
                            we    = 1'b1;
                            waddr = pos_addr;
                            wdata = {attr_reg, ch_reg};
                        end
                    end

                    ACT_READ:
                    begin
                        if (in_range)
                        begin
                            re         = 1'b1;
                            raddr      = pos_addr;
                            state_next = ST_READ;
                        end
                    end

                    ACT_CLEAR:
                    begin
                        cursor_next = '0;
                        ccol_next   = '0;
                        crow_next   = '0;
                        cnt_next    = '0;
                        state_next  = ST_FILL;
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SCROLL:
            begin
                // read cell n, write it one row up in the next cycle
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = dst_reg;
                    wdata = ram_rdata;
                end
                if (cnt_reg != CW'(CELLS))
                begin
                    re        = 1'b1;
                    raddr     = cnt_reg[AW-1:0];
                    dst_next  = AW'(cnt_reg - CW'(COLUMNS));
                    pend_next = 1'b1;
                    cnt_next  = cnt_inc;
                end
                else
                begin
                    pend_next  = 1'b0;
                    cnt_next   = CW'(CELLS - COLUMNS);
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                we    = 1'b1;
                waddr = cnt_reg[AW-1:0];
                wdata = BLANK_CELL;
                if (cnt_reg == CW'(CELLS - 1))
                begin
                    state_next = put_pend_reg ? ST_PUT : ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end

            ST_PUT:
            begin
                we            = 1'b1;
                waddr         = AW'(CELLS - COLUMNS);
                wdata         = {attr_reg, ch_reg};
                put_pend_next = 1'b0;
                state_next    = ST_DONE;
            end

            ST_READ:
            begin
                rd_char_next = ram_rdata[7:0];
                rd_attr_next = ram_rdata[15:8];
                state_next   = ST_DONE;
            end

            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_req = '{
        we:    we,
        waddr: ADDR_MAX_W'(waddr),
        wdata: wdata,
        re:    re,
        raddr: ADDR_MAX_W'(raddr)
    };

    assign busy            = (state_reg != ST_IDLE);
    assign cursor_position = CURSOR_OUT_W'(cursor_reg);
    assign cell_char       = rd_char_reg;
    assign cell_attribute  = rd_attr_reg;

endmodule

`default_nettype wire

/* sv/text_console_writer.sv */
// channel   | signals                                          | handshake
// ----------+--------------------------------------------------+-------------------------
// command   | action char_code attribute use_default at_cursor | start & !busy
//           | column row                                       |
// result    | cursor_position cell_char cell_attribute         | done, one cycle, no stall
// config    | psel penable pwrite paddr pwdata prdata pready   | APB, pready tied high
//
// A put, backspace, newline or positioned write goes through decode to the done strobe,
// and the next item is taken only once the block is idle again; a read adds a state for
// the RAM read. A scroll adds one read per moved cell, each written back one row up from
// the registered read data, then one fill write per cell of the last row, plus a write
// for a put that triggered it. Clear does one fill write per cell. rst_n homes the
// cursor and sets default_attribute to 0x0F; the screen is undefined until cleared or
// written. Results cannot be stalled.
//
// Top level: APB register, screen RAM and sequencer. Depends on tcw_pkg,
// tcw_ram and tcw_ctrl.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              action,
    input  wire logic [7:0]              char_code,
    input  wire logic [7:0]              attribute,
    input  wire logic                    use_default,
    input  wire logic                    at_cursor,
    input  wire logic [6:0]              column,
    input  wire logic [4:0]              row,
    output logic                         done,
    output logic [CURSOR_OUT_W-1:0]      cursor_position,
    output logic [7:0]                   cell_char,
    output logic [7:0]                   cell_attribute,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [7:0]        default_attr_reg;
    ram_req_t          ram_req;
    logic [CELL_W-1:0] ram_rdata;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= DEFAULT_ATTR_RST;
        end
        else if (cfg_write && paddr[2] == REG_DEFAULT_ATTR)
        begin
            default_attr_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEFAULT_ATTR) ? {24'd0, default_attr_reg} : '0;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr[AW-1:0]),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr[AW-1:0]),
        .rdata (ram_rdata)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .action            (action),
        .char_code         (char_code),
        .attribute         (attribute),
        .use_default       (use_default),
        .at_cursor         (at_cursor),
        .column            (column),
        .row               (row),
        .default_attribute (default_attr_reg),
        .ram_rdata         (ram_rdata),
        .ram_req           (ram_req),
        .busy              (busy),
        .done              (done),
        .cursor_position   (cursor_position),
        .cell_char         (cell_char),
        .cell_attribute    (cell_attribute)
    );

endmodule

`default_nettype wire

/* sv/tcw_checker.sv */
// Port-level checker for text_console_writer, attached by bind.
// Depends on text_console_writer_assert.svh.
`default_nettype none

`include "text_console_writer_assert.svh"

module tcw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [10:0] cursor_position
);

    // an accepted item keeps the block busy until its result
    `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

    `TCW_ASSERT_IMPL(a_done_busy, done, busy, "result strobe outside an item")

    // exactly one result per item
    `TCW_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")

    // cursor only moves while an item is in flight
    `TCW_ASSERT_IMPL(a_cursor_idle, !busy && $past(!busy), $stable(cursor_position),
                     "cursor changed while idle")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .cursor_position (cursor_position)
);

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for text_console_writer: a screen/cursor scoreboard predicts
// every item's report, and tasks drive commands and APB writes. Depends on tcw_pkg.
`timescale 1ns / 100ps

module testbench;
    import tcw_pkg::*;

    localparam int COLS  = COLUMNS_DEF;
    localparam int ROWS  = ROWS_DEF;
    localparam int CELLS = COLS * ROWS;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [2:0] ADDR_DEFAULT_ATTR = {REG_DEFAULT_ATTR, 2'b00};

    localparam int ITEMS_PER_PHASE = 175;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 15_000_000;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       use_def;
        logic       at_cur;
        logic [6:0] col;
        logic [4:0] rw;
    } console_cmd_t;

    typedef struct packed {
        logic [10:0] pos;
        logic [7:0]  ch;
        logic [7:0]  attr;
    } console_report_t;

    class console_scoreboard;
        bit [7:0]        scr_char [CELLS];
        bit [7:0]        scr_attr [CELLS];
        int unsigned     cur;
        bit [7:0]        dflt_attr;
        console_report_t awaited_reports [$];
        int              errors;

        function new();
            cur = 0;
            dflt_attr = DEFAULT_ATTR_RST;
            errors = 0;
        endfunction

        function void set_default_attr(bit [7:0] v);
            dflt_attr = v;
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        function int room_in_row();
            return COLS - (cur % COLS);
        endfunction

        function void fill_blank(int unsigned lo, int unsigned hi);
            for (int unsigned i = lo; i < hi; i++)
            begin
                scr_char[i] = SPACE_CHAR;
                scr_attr[i] = BLANK_ATTR;
            end
        endfunction

        function void scroll_up();
            for (int unsigned i = 0; i < CELLS - COLS; i++)
            begin
                scr_char[i] = scr_char[i + COLS];
                scr_attr[i] = scr_attr[i + COLS];
            end
            fill_blank(CELLS - COLS, CELLS);
        endfunction

        // advance the screen and cursor by one accepted item, queue its report
        function void note_command(console_cmd_t c);
            bit [7:0]        a;
            console_report_t r;
            a = c.use_def ? dflt_attr : c.attr;
            r.ch = '0;
            r.attr = '0;
            case (c.act)
                ACT_PUT:
                begin
                    if (c.ch == NEWLINE_CHAR)
                    begin
                        if (cur / COLS >= ROWS - 1)
                        begin
                            scroll_up();
                            cur -= COLS;
                        end
                        cur = (cur / COLS + 1) * COLS;
                    end
                    else if (c.ch == BACKSPACE_CHAR)
                    begin
                        if (cur != 0)
                        begin
                            cur -= 1;
                            scr_char[cur] = SPACE_CHAR;
                            scr_attr[cur] = a;
                        end
                    end
                    else if (c.at_cur)
                    begin
                        if (cur >= CELLS)
                        begin
                            scroll_up();
                            cur -= COLS;
                        end
                        scr_char[cur] = c.ch;
                        scr_attr[cur] = a;
                        cur += 1;
                    end
                    else if (c.col < COLS && c.rw < ROWS)
                    begin
                        scr_char[c.rw * COLS + c.col] = c.ch;
                        scr_attr[c.rw * COLS + c.col] = a;
                    end
                end
                ACT_READ:
                begin
                    if (c.col < COLS && c.rw < ROWS)
                    begin
                        r.ch   = scr_char[c.rw * COLS + c.col];
                        r.attr = scr_attr[c.rw * COLS + c.col];
                    end
                end
                ACT_CLEAR:
                begin
                    fill_blank(0, CELLS);
                    cur = 0;
                end
                default: ;
            endcase
            r.pos = cur[10:0];
            awaited_reports.push_back(r);
        endfunction

        function void check_result(logic [10:0] pos, logic [7:0] ch, logic [7:0] attr);
            console_report_t e;
            if (awaited_reports.size() == 0)
            begin
                $error("unexpected result: cursor_position %0d cell_char %0d cell_attribute %0d",
                       pos, ch, attr);
                errors++;
                return;
            end
            e = awaited_reports.pop_front();
            if (pos !== e.pos)
            begin
                $error("cursor_position: expected %0d, actual %0d", e.pos, pos);
                errors++;
            end
            if (ch !== e.ch)
            begin
                $error("cell_char: expected 0x%02h, actual 0x%02h", e.ch, ch);
                errors++;
            end
            if (attr !== e.attr)
            begin
                $error("cell_attribute: expected 0x%02h, actual 0x%02h", e.attr, attr);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  action = '0;
    logic [7:0]  char_code = '0;
    logic [7:0]  attribute = '0;
    logic        use_default = 1'b0;
    logic        at_cursor = 1'b0;
    logic [6:0]  column = '0;
    logic [4:0]  row = '0;
    logic        done;
    logic [10:0] cursor_position;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attribute;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    console_scoreboard sb;
    int cycle_count = 0;
    int items_sent = 0;
    int burst_left = 0;

    text_console_writer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .char_code       (char_code),
        .attribute       (attribute),
        .use_default     (use_default),
        .at_cursor       (at_cursor),
        .column          (column),
        .row             (row),
        .done            (done),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attribute  (cell_attribute),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("text_console_writer verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(cursor_position, cell_char, cell_attribute);
    end

    function automatic console_cmd_t make_cmd(logic [1:0] act, logic [7:0] ch,
                                              logic [7:0] attr, logic use_def,
                                              logic at_cur, logic [6:0] col,
                                              logic [4:0] rw);
        console_cmd_t c;
        c.act = act;
        c.ch = ch;
        c.attr = attr;
        c.use_def = use_def;
        c.at_cur = at_cur;
        c.col = col;
        c.rw = rw;
        return c;
    endfunction

    function automatic console_cmd_t text_cmd();
        logic [7:0] ch;
        ch = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(32, 126));
        return make_cmd(ACT_PUT, ch, 8'($urandom), $urandom_range(0, 3) == 0, 1'b1,
                        7'($urandom), 5'($urandom));
    endfunction

    function automatic console_cmd_t located_cmd(logic [1:0] act);
        logic [6:0] col;
        logic [4:0] rw;
        col = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, COLS - 1));
        rw  = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, ROWS - 1));
        return make_cmd(act, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, col, rw);
    endfunction

    // hold start until the block takes the item, then maybe open a gap
    task automatic issue(input console_cmd_t c);
        start       <= 1'b1;
        action      <= c.act;
        char_code   <= c.ch;
        attribute   <= c.attr;
        use_default <= c.use_def;
        at_cursor   <= c.at_cur;
        column      <= c.col;
        row         <= c.rw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(c);
        if (c.act != ACT_SPARE)
            items_sent++;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic quiesce();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_default_attr(input logic [7:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_DEFAULT_ATTR;
        pwdata  <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_default_attr(v);
        @(posedge clk);
    endtask

    task automatic text_run();
        int len;
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            len = sb.room_in_row();
        else if (r < 4)
            len = $urandom_range(60, 170);
        else
            len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                issue(make_cmd(ACT_PUT, BACKSPACE_CHAR, 8'($urandom), 1'($urandom),
                               1'($urandom), 7'($urandom), 5'($urandom)));
            else
                issue(text_cmd());
        end
        repeat ($urandom_range(1, 3))
            issue(make_cmd(ACT_PUT, NEWLINE_CHAR, 8'($urandom), 1'($urandom),
                           1'($urandom), 7'($urandom), 5'($urandom)));
    endtask

    task automatic random_phase(input int quota);
        int target;
        int r;
        target = items_sent + quota;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                text_run();
            else if (r < 85)
                repeat ($urandom_range(1, 4))
                    issue(located_cmd(ACT_READ));
            else if (r < 95)
                repeat ($urandom_range(1, 3))
                    issue(located_cmd(ACT_PUT));
            else if (r < 97)
                issue(make_cmd(ACT_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom),
                               1'($urandom), 7'($urandom), 5'($urandom)));
            else
                issue(make_cmd(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                               1'($urandom), 7'($urandom), 5'($urandom)));
        end
    endtask

    initial
    begin
        logic [7:0] settings [4];
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = 8'($urandom_range(1, 254));
        settings[3] = 8'($urandom_range(1, 254));
        sb = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clear first so no read ever hits a cell that was never written
        issue(make_cmd(ACT_CLEAR, 8'h00, 8'h00, 1'b0, 1'b0, 7'd0, 5'd0));
        issue(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b0, 1'b0, 7'd0, 5'd0));
        issue(make_cmd(ACT_PUT, 8'h41, 8'h00, 1'b0, 1'b1, 7'd0, 5'd0));
        issue(make_cmd(ACT_PUT, 8'hFF, 8'hFF, 1'b0, 1'b1, 7'd127, 5'd31));
        issue(make_cmd(ACT_PUT, 8'h00, 8'h33, 1'b1, 1'b1, 7'd0, 5'd0));
        issue(make_cmd(ACT_PUT, 8'h7E, 8'hA5, 1'b0, 1'b0, 7'(COLS - 1), 5'(ROWS - 1)));
        issue(make_cmd(ACT_PUT, 8'h5A, 8'h5A, 1'b0, 1'b0, 7'd0, 5'd0));
        issue(make_cmd(ACT_PUT, 8'h21, 8'h12, 1'b0, 1'b0, 7'd127, 5'd0));
        issue(make_cmd(ACT_PUT, 8'h22, 8'h34, 1'b1, 1'b0, 7'd0, 5'd31));
        issue(make_cmd(ACT_READ, 8'hFF, 8'hFF, 1'b1, 1'b1, 7'(COLS - 1), 5'(ROWS - 1)));
        issue(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b0, 1'b0, 7'd0, 5'd0));
        issue(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b0, 1'b0, 7'd127, 5'd31));
        issue(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b0, 1'b0, 7'(COLS), 5'd3));
        issue(make_cmd(ACT_SPARE, 8'hC3, 8'h3C, 1'b1, 1'b1, 7'd45, 5'd17));
        issue(make_cmd(ACT_PUT, NEWLINE_CHAR, 8'h00, 1'b0, 1'b1, 7'd0, 5'd0));
        issue(make_cmd(ACT_PUT, BACKSPACE_CHAR, 8'h9C, 1'b0, 1'b1, 7'd0, 5'd0));
        issue(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b0, 1'b0, 7'(COLS - 1), 5'd0));
        issue(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b0, 1'b0, 7'd1, 5'd0));
        issue(make_cmd(ACT_CLEAR, 8'hFF, 8'hFF, 1'b1, 1'b1, 7'd127, 5'd31));
        issue(make_cmd(ACT_PUT, BACKSPACE_CHAR, 8'h55, 1'b0, 1'b1, 7'd0, 5'd0));
        // newline and backspace ignore the given position
        issue(make_cmd(ACT_PUT, NEWLINE_CHAR, 8'hAA, 1'b1, 1'b0, 7'd50, 5'd20));
        issue(make_cmd(ACT_PUT, BACKSPACE_CHAR, 8'h00, 1'b1, 1'b0, 7'd3, 5'd3));
        issue(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b0, 1'b0, 7'(COLS - 1), 5'd0));
        quiesce();

        for (int p = 0; p < 4; p++)
        begin
            write_default_attr(settings[p]);
            random_phase(ITEMS_PER_PHASE);
            quiesce();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("text_console_writer verification clean");
        else
            $display("text_console_writer verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
verif/testbench.sv
